// ===== hw/rtl/ssrd_pkg.sv =====
package ssrd_pkg;

    localparam int MAX_GRID_DEF  = 8;
    localparam int FRAC_BITS_DEF = 14;

    localparam int VEC_W   = 48;
    localparam int LANE_W  = 16;
    localparam int GRID_W  = 4;
    localparam int IDX_W   = 3;
    localparam int DIR_W   = 16;
    localparam int CFG_A_W = 2;

    typedef enum logic [CFG_A_W-1:0] {
        REG_GRID_SIZE = 2'd0,
        REG_STEP_A    = 2'd1,
        REG_STEP_B    = 2'd2,
        REG_BASE      = 2'd3
    } cfg_reg_t;

endpackage

// ===== hw/rtl/ssrd_front.sv =====
module ssrd_front #(
    parameter int MAX_GRID = 8,
    parameter int CW       = 3,
    parameter int SW       = 22,
    parameter int SQW      = 42,
    parameter int NW       = 44,
    parameter int EW       = 240
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ssrd_pkg::GRID_W-1:0]   grid_size,
    input  logic [ssrd_pkg::VEC_W-1:0]    step_a,
    input  logic [ssrd_pkg::VEC_W-1:0]    step_b,
    input  logic [ssrd_pkg::VEC_W-1:0]    base_dir,
    output logic                          busy,
    input  logic                          q_full,
    output logic                          q_push,
    output logic [EW-1:0]                 q_data
);
    import ssrd_pkg::*;

    localparam int HW = $clog2(MAX_GRID + 1) + 2;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_CALC = 4'b0010,
        F_SQ   = 4'b0100,
        F_PUSH = 4'b1000
    } fstate_t;

    fstate_t state_reg, state_next;
    logic [CW-1:0] row_reg, row_next, col_reg, col_next;
    logic [1:0]    k_reg, k_next;
    logic [CW:0]   n_reg, n_next;
    logic signed [SW-1:0] s_reg [3];
    logic signed [SW-1:0] s_next [3];
    logic [SQW-1:0] sq_reg [3];
    logic [SQW-1:0] sq_next [3];
    logic [NW-1:0]  norm_reg, norm_next;

    logic [CW:0]           n_clamp;
    logic signed [HW-1:0]  h_row, h_col;
    logic signed [SW-1:0]  s_sel;
    logic [SW-1:0]         mag;
    logic [SQW-1:0]        mag_sq;
    logic                  is_last;

    always_comb
    begin
        if (grid_size == '0)
            n_clamp = (CW+1)'(1);
        else if (32'(grid_size) > MAX_GRID)
            n_clamp = (CW+1)'(MAX_GRID);
        else
            n_clamp = (CW+1)'(grid_size);
    end

    assign h_row = HW'(signed'({1'b0, row_reg, 1'b0})) - HW'(signed'({1'b0, n_reg}))
                   + HW'(1);
    assign h_col = HW'(signed'({1'b0, col_reg, 1'b0})) - HW'(signed'({1'b0, n_reg}))
                   + HW'(1);

    assign s_sel  = s_reg[k_reg];
    assign mag    = s_sel[SW-1] ? SW'(-s_sel) : SW'(s_sel);
    assign mag_sq = SQW'(mag[SW-2:0] * mag[SW-2:0]);

    assign is_last = ({1'b0, row_reg} == n_reg - 1'b1) && ({1'b0, col_reg} == n_reg - 1'b1);

    assign busy   = (state_reg != F_IDLE);
    assign q_push = (state_reg == F_PUSH) && !q_full;
    assign q_data = {is_last, col_reg, row_reg, norm_reg,
                     sq_reg[2], sq_reg[1], sq_reg[0], s_reg[2], s_reg[1], s_reg[0]};

    always_comb
    begin
        logic signed [SW-1:0] lb, la, lc, hr, hc;
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        norm_next  = norm_reg;
        s_next     = s_reg;
        sq_next    = sq_reg;
        lb = '0;
        la = '0;
        lc = '0;
        hr = SW'(h_row);
        hc = SW'(h_col);
        unique case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    n_next     = n_clamp;
                    row_next   = '0;
                    col_next   = '0;
                    state_next = F_CALC;
                end
            end
            F_CALC:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    lb = SW'(signed'(base_dir[LANE_W*c +: LANE_W]));
                    la = SW'(signed'(step_a[LANE_W*c +: LANE_W]));
                    lc = SW'(signed'(step_b[LANE_W*c +: LANE_W]));
                    s_next[c] = SW'(lb + lb + la * hr + lc * hc);
                end
                k_next     = '0;
                norm_next  = '0;
                state_next = F_SQ;
            end
            F_SQ:
            begin
                sq_next[k_reg] = mag_sq;
                norm_next      = norm_reg + NW'(mag_sq);
                k_next         = k_reg + 2'd1;
                if (k_reg == 2'd2)
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    if (is_last)
                        state_next = F_IDLE;
                    else
                    begin
                        state_next = F_CALC;
                        if ({1'b0, col_reg} == n_reg - 1'b1)
                        begin
                            col_next = '0;
                            row_next = row_reg + 1'b1;
                        end
                        else
                            col_next = col_reg + 1'b1;
                    end
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            n_reg     <= (CW+1)'(1);
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        norm_reg <= norm_next;
        s_reg    <= s_next;
        sq_reg   <= sq_next;
    end

endmodule

// ===== hw/rtl/ssrd_queue.sv =====
module ssrd_queue #(
    parameter int EW = 240
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [EW-1:0] wr_data,
    input  logic          pop,
    output logic [EW-1:0] rd_data,
    output logic          full,
    output logic          empty
);
    logic [EW-1:0] mem_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== hw/rtl/ssrd_back.sv =====
module ssrd_back #(
    parameter int FRAC_BITS = 14,
    parameter int CW        = 3,
    parameter int SW        = 22,
    parameter int SQW       = 42,
    parameter int NW        = 44,
    parameter int EW        = 240
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_empty,
    input  logic [EW-1:0]                      q_data,
    output logic                               q_pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [ssrd_pkg::DIR_W-1:0]  dir_x,
    output logic signed [ssrd_pkg::DIR_W-1:0]  dir_y,
    output logic signed [ssrd_pkg::DIR_W-1:0]  dir_z,
    output logic [ssrd_pkg::IDX_W-1:0]         row_index,
    output logic [ssrd_pkg::IDX_W-1:0]         col_index,
    output logic                               last
);
    import ssrd_pkg::*;

    localparam int LW  = 2 * DIR_W + 2 + NW;
    localparam int RW  = SQW + 2 * FRAC_BITS + 2;
    localparam int WW  = ((LW > RW) ? LW : RW) + 1;
    localparam int BW  = $clog2(DIR_W);

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_INIT = 5'b00010,
        B_STA  = 5'b00100,
        B_STB  = 5'b01000,
        B_OUT  = 5'b10000
    } bstate_t;

    bstate_t state_reg, state_next;
    logic [EW-1:0]    ent_reg, ent_next;
    logic [1:0]       k_reg, k_next;
    logic [BW-1:0]    b_reg, b_next;
    logic [DIR_W-1:0] q_reg, q_next;
    logic [WW-1:0]    p_reg, p_next, qn_reg, qn_next;
    logic [WW-1:0]    c2n_reg, c2n_next, cn_reg, cn_next;
    logic [WW-1:0]    r_reg, r_next;
    logic [DIR_W-1:0] res_reg [3];
    logic [DIR_W-1:0] res_next [3];
    logic             ov_reg, ov_next;
    logic [DIR_W-1:0] ox_reg, oy_reg, oz_reg;
    logic [IDX_W-1:0] orow_reg, ocol_reg;
    logic             olast_reg;

    logic signed [SW-1:0] s_sel;
    logic [SQW-1:0]       sq_sel;
    logic [NW-1:0]        norm;
    logic [CW-1:0]        e_row, e_col;
    logic                 e_last;
    logic [WW-1:0]        n_ext, lhs;
    logic                 fits;
    logic [DIR_W-1:0]     cap, mag_q, fin;
    logic                 load_out;

    assign s_sel  = ent_reg[SW*k_reg +: SW];
    assign sq_sel = ent_reg[3*SW + SQW*k_reg +: SQW];
    assign norm   = ent_reg[3*SW + 3*SQW +: NW];
    assign e_row  = ent_reg[3*SW + 3*SQW + NW +: CW];
    assign e_col  = ent_reg[3*SW + 3*SQW + NW + CW +: CW];
    assign e_last = ent_reg[EW-1];

    assign n_ext = WW'(norm);
    assign lhs   = (c2n_reg << 2) + n_ext - (cn_reg << 2);
    assign fits  = (lhs <= r_reg);

    // final digit folded in: q with or without bit b
    always_comb
    begin
        logic [DIR_W-1:0] qf;
        qf    = fits ? (q_reg | (DIR_W'(1) << b_reg)) : q_reg;
        cap   = s_sel[SW-1] ? (DIR_W'(1) << (DIR_W - 1)) : ~(DIR_W'(1) << (DIR_W - 1));
        mag_q = (qf > cap) ? cap : qf;
        if (norm == '0)
            fin = '0;
        else
            fin = s_sel[SW-1] ? DIR_W'(0 - mag_q) : mag_q;
    end

    assign q_pop    = (state_reg == B_IDLE) && !q_empty;
    assign load_out = (state_reg == B_OUT) && (!ov_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        ent_next   = ent_reg;
        k_next     = k_reg;
        b_next     = b_reg;
        q_next     = q_reg;
        p_next     = p_reg;
        qn_next    = qn_reg;
        c2n_next   = c2n_reg;
        cn_next    = cn_reg;
        r_next     = r_reg;
        res_next   = res_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    ent_next   = q_data;
                    k_next     = '0;
                    state_next = B_INIT;
                end
            end
            B_INIT:
            begin
                q_next     = '0;
                p_next     = '0;
                qn_next    = '0;
                b_next     = BW'(DIR_W - 1);
                r_next     = WW'(sq_sel) << (2 * FRAC_BITS + 2);
                state_next = B_STA;
            end
            B_STA:
            begin
                c2n_next   = p_reg + (qn_reg << (b_reg + 1'b1)) + (n_ext << (2 * b_reg));
                cn_next    = qn_reg + (n_ext << b_reg);
                state_next = B_STB;
            end
            B_STB:
            begin
                if (fits)
                begin
                    q_next  = q_reg | (DIR_W'(1) << b_reg);
                    p_next  = c2n_reg;
                    qn_next = cn_reg;
                end
                if (b_reg == '0)
                begin
                    res_next[k_reg] = fin;
                    if (k_reg == 2'd2)
                        state_next = B_OUT;
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = B_INIT;
                    end
                end
                else
                begin
                    b_next     = b_reg - 1'b1;
                    state_next = B_STA;
                end
            end
            B_OUT:
            begin
                if (load_out)
                    state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (load_out)
            ov_next = 1'b1;
        else if (ov_reg && !out_stall)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
            k_reg     <= '0;
            b_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            k_reg     <= k_next;
            b_reg     <= b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
        q_reg   <= q_next;
        p_reg   <= p_next;
        qn_reg  <= qn_next;
        c2n_reg <= c2n_next;
        cn_reg  <= cn_next;
        r_reg   <= r_next;
        res_reg <= res_next;
        if (load_out)
        begin
            ox_reg    <= res_reg[0];
            oy_reg    <= res_reg[1];
            oz_reg    <= res_reg[2];
            orow_reg  <= IDX_W'(e_row);
            ocol_reg  <= IDX_W'(e_col);
            olast_reg <= e_last;
        end
    end

    assign out_valid = ov_reg;
    assign dir_x     = ox_reg;
    assign dir_y     = oy_reg;
    assign dir_z     = oz_reg;
    assign row_index = orow_reg;
    assign col_index = ocol_reg;
    assign last      = olast_reg;

endmodule

// ===== hw/rtl/supersample_ray_direction_gen_top.sv =====
// channel | handshake                  | payload
// --------+----------------------------+-------------------------------------------
// cfg     | cfg_valid / cfg_ready      | cfg_index, cfg_data
// in      | in_valid / in_stall        | begin_req
// out     | out_valid / out_stall      | dir_x, dir_y, dir_z, row_index, col_index, last
//
// one request gives n*n rays; the front walks each ray through an offset sum, three
// serial squares and a queue push, and the back runs a shift-add bit search over
// 16 result bits per component, one result bit per B_STA/B_STB pair. in_stall is
// high while the front walks a grid. rst_n clears the fsms, the queue and the
// output flag; config resets to grid size 1, zero vectors
module supersample_ray_direction_gen_top #(
    parameter int MAX_GRID  = ssrd_pkg::MAX_GRID_DEF,
    parameter int FRAC_BITS = ssrd_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ssrd_pkg::CFG_A_W-1:0]       cfg_index,
    input  logic [ssrd_pkg::VEC_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               begin_req,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [ssrd_pkg::DIR_W-1:0]  dir_x,
    output logic signed [ssrd_pkg::DIR_W-1:0]  dir_y,
    output logic signed [ssrd_pkg::DIR_W-1:0]  dir_z,
    output logic [ssrd_pkg::IDX_W-1:0]         row_index,
    output logic [ssrd_pkg::IDX_W-1:0]         col_index,
    output logic                               last
);
    import ssrd_pkg::*;

    // grid counters, offset sum and squared norm widths
    localparam int CW  = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
    localparam int HW  = $clog2(MAX_GRID + 1) + 2;
    localparam int SW  = LANE_W + HW + 2;
    localparam int SQW = 2 * SW - 2;
    localparam int NW  = SQW + 2;
    localparam int EW  = 3 * SW + 3 * SQW + NW + 2 * CW + 1;

    logic [GRID_W-1:0] grid_size_reg;
    logic [VEC_W-1:0]  step_a_reg, step_b_reg, base_reg;

    logic          front_busy, q_full, q_empty, q_push, q_pop;
    logic [EW-1:0] q_wdata, q_rdata;

    // config writes always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= GRID_W'(1);
            step_a_reg    <= '0;
            step_b_reg    <= '0;
            base_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GRID_SIZE: grid_size_reg <= cfg_data[GRID_W-1:0];
                REG_STEP_A:    step_a_reg    <= cfg_data;
                REG_STEP_B:    step_b_reg    <= cfg_data;
                REG_BASE:      base_reg      <= cfg_data;
                default:       ;
            endcase
        end
    end

    // a transaction with begin_req low is taken and dropped
    assign in_stall = front_busy;

    ssrd_front #(
        .MAX_GRID (MAX_GRID),
        .CW       (CW),
        .SW       (SW),
        .SQW      (SQW),
        .NW       (NW),
        .EW       (EW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && !front_busy && begin_req),
        .grid_size (grid_size_reg),
        .step_a    (step_a_reg),
        .step_b    (step_b_reg),
        .base_dir  (base_reg),
        .busy      (front_busy),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    // two-entry queue decouples grid walk from normalizer
    ssrd_queue #(
        .EW (EW)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wdata),
        .pop     (q_pop),
        .rd_data (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    ssrd_back #(
        .FRAC_BITS (FRAC_BITS),
        .CW        (CW),
        .SW        (SW),
        .SQW       (SQW),
        .NW        (NW),
        .EW        (EW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .dir_z     (dir_z),
        .row_index (row_index),
        .col_index (col_index),
        .last      (last)
    );

endmodule
